[design/pss_pkg.sv]
package pss_pkg;

  localparam int POS_FRAC_BITS  = 16;
  localparam int UNIT_FRAC_BITS = 14;

  localparam int PW    = 32;   // position width
  localparam int UW    = 16;   // unit vector component width
  localparam int CFG_W = 24;
  localparam int DT_W  = 20;
  localparam int VW    = 34;   // working vector component width
  localparam int AW    = 40;   // wide accumulate width for integration
  localparam int THR_W = 8;

  localparam logic [UW-1:0] UNIT_ONE = UW'(1 << UNIT_FRAC_BITS);

  localparam longint unsigned SPEED_EPS_SQ =
    ((64'd1 << (2 * POS_FRAC_BITS)) + 64'd50000000) / 64'd100000000;
  localparam longint unsigned RIGHT_EPS_SQ =
    ((64'd1 << (2 * UNIT_FRAC_BITS)) + 64'd50000000) / 64'd100000000;

  localparam logic [CFG_W-1:0] CHASE_RST = 24'd1310720;
  localparam logic [CFG_W-1:0] STEER_RST = 24'd655360;

  // register indexes
  localparam logic CFG_CHASE = 1'b0;
  localparam logic CFG_STEER = 1'b1;

  typedef logic signed [VW-1:0] vw_t;

  typedef enum logic [2:0] {
    SRC_D,
    SRC_STEER,
    SRC_VEL,
    SRC_FWD,
    SRC_RT
  } src_e;

  typedef struct packed {
    logic       vu_start;
    src_e       src;
    logic       load_in;
    logic       wb_des;
    logic       wb_steer;
    logic       mdt_vel;
    logic       wb_vel;
    logic       mdt_pos;
    logic       wb_fwd;
    logic       wb_right;
    logic       calc_up;
    logic       load_out;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic vu_busy;
    logic vu_done;
    logic out_free;
  } sts_t;

endpackage

[design/pss_if.sv]
interface pss_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [pss_pkg::PW-1:0]     target_x;
  logic signed [pss_pkg::PW-1:0]     target_y;
  logic signed [pss_pkg::PW-1:0]     target_z;
  logic        [pss_pkg::DT_W-1:0]   step_time;

  modport source (output valid, target_x, target_y, target_z, step_time, input ready);
  modport sink (input valid, target_x, target_y, target_z, step_time, output ready);
endinterface

interface pss_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [pss_pkg::UW-1:0] right_x;
  logic signed [pss_pkg::UW-1:0] right_y;
  logic signed [pss_pkg::UW-1:0] right_z;
  logic signed [pss_pkg::UW-1:0] up_x;
  logic signed [pss_pkg::UW-1:0] up_y;
  logic signed [pss_pkg::UW-1:0] up_z;
  logic signed [pss_pkg::UW-1:0] fwd_x;
  logic signed [pss_pkg::UW-1:0] fwd_y;
  logic signed [pss_pkg::UW-1:0] fwd_z;
  logic signed [pss_pkg::PW-1:0] pos_x;
  logic signed [pss_pkg::PW-1:0] pos_y;
  logic signed [pss_pkg::PW-1:0] pos_z;

  modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                  fwd_x, fwd_y, fwd_z, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                fwd_x, fwd_y, fwd_z, pos_x, pos_y, pos_z, output ready);
endinterface

[design/pss_vunit.sv]
module pss_vunit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  pss_pkg::vw_t                vec_i [3],
  input  logic [pss_pkg::CFG_W-1:0]   tgt_i,
  input  logic                        rnd_i,
  input  logic                        clamp_i,
  input  logic [pss_pkg::THR_W-1:0]   thr_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic                        scaled_o,
  output pss_pkg::vw_t                res_o [3]
);

  localparam int VW = pss_pkg::VW;
  localparam int QW = pss_pkg::CFG_W + 1;         // quotient never exceeds target
  localparam int NW = 31 + pss_pkg::CFG_W + 1;    // numerator width

  localparam logic [3:0] V_IDLE  = 4'd0;
  localparam logic [3:0] V_SHIFT = 4'd1;
  localparam logic [3:0] V_SQ    = 4'd2;
  localparam logic [3:0] V_SQI   = 4'd3;
  localparam logic [3:0] V_SQRT  = 4'd4;
  localparam logic [3:0] V_DEC   = 4'd5;
  localparam logic [3:0] V_MUL   = 4'd6;
  localparam logic [3:0] V_DIV   = 4'd7;
  localparam logic [3:0] V_DONE  = 4'd8;

  logic [3:0]                 state_q, state_d;
  logic [VW-1:0]              mag_q [3];
  logic                       neg_q [3];
  pss_pkg::vw_t               orig_q [3];
  pss_pkg::vw_t               res_q [3];
  logic                       shifted_q, scaled_q, rnd_q, clamp_q;
  logic [pss_pkg::CFG_W-1:0]  tgt_q;
  logic [63:0]                sum_q, thr_q, x_q, r_q, bit_q;
  logic [4:0]                 cnt_q;
  logic [1:0]                 idx_q;
  logic [31:0]                rem_q;
  logic [QW-1:0]              nlo_q, q_q;

  logic [VW-1:0]  mag_sel;
  logic [31:0]    mul_a, mul_b;
  logic [63:0]    prod, rb;
  logic [31:0]    len;
  logic [NW-1:0]  num;
  logic [32:0]    trial;
  logic           ge, big, cond, sq_ge;
  logic [31:0]    rem_nx;
  logic [QW-1:0]  q_nx;

  always_comb begin
    case (idx_q)
      2'd0:    mag_sel = mag_q[0];
      2'd1:    mag_sel = mag_q[1];
      default: mag_sel = mag_q[2];
    endcase
  end

  always_comb begin
    if (state_q == V_SQ && idx_q == 2'd3) begin
      mul_a = 32'(tgt_q);
      mul_b = 32'(tgt_q);
    end else if (state_q == V_MUL) begin
      mul_a = {1'b0, mag_sel[30:0]};
      mul_b = 32'(tgt_q);
    end else begin
      mul_a = {1'b0, mag_sel[30:0]};
      mul_b = {1'b0, mag_sel[30:0]};
    end
  end

  assign prod   = mul_a * mul_b;
  assign len    = r_q[31:0];
  assign num    = prod[NW-1:0] + (rnd_q ? NW'(len >> 1) : NW'(0));
  assign trial  = {rem_q, nlo_q[QW-1]};
  assign ge     = trial >= {1'b0, len};
  assign rem_nx = ge ? 32'(trial - {1'b0, len}) : trial[31:0];
  assign q_nx   = {q_q[QW-2:0], ge};
  assign rb     = r_q + bit_q;
  assign sq_ge  = x_q >= rb;
  assign big    = |(mag_q[0][VW-1:31] | mag_q[1][VW-1:31] | mag_q[2][VW-1:31]);
  assign cond   = shifted_q || (sum_q > thr_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      V_IDLE:  if (start_i) state_d = V_SHIFT;
      V_SHIFT: if (!big) state_d = V_SQ;
      V_SQ: begin
        if ((idx_q == 2'd2 && !clamp_q) || idx_q == 2'd3) state_d = V_SQI;
      end
      V_SQI:   state_d = V_SQRT;
      V_SQRT:  if (cnt_q == 5'd31) state_d = V_DEC;
      V_DEC:   state_d = cond ? V_MUL : V_DONE;
      V_MUL:   state_d = V_DIV;
      V_DIV: begin
        if (cnt_q == 5'(QW-1)) state_d = (idx_q == 2'd2) ? V_DONE : V_MUL;
      end
      V_DONE:  state_d = V_IDLE;
      default: state_d = V_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= V_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      V_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            neg_q[i]  <= vec_i[i][VW-1];
            mag_q[i]  <= vec_i[i][VW-1] ? VW'(-vec_i[i]) : VW'(vec_i[i]);
            orig_q[i] <= vec_i[i];
          end
          tgt_q     <= tgt_i;
          rnd_q     <= rnd_i;
          clamp_q   <= clamp_i;
          thr_q     <= 64'(thr_i);
          shifted_q <= 1'b0;
        end
      end
      V_SHIFT: begin
        if (big) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          shifted_q <= 1'b1;
        end else begin
          idx_q <= 2'd0;
          sum_q <= '0;
        end
      end
      V_SQ: begin
        if (idx_q == 2'd3) thr_q <= prod;
        else sum_q <= sum_q + prod;
        idx_q <= idx_q + 2'd1;
      end
      V_SQI: begin
        x_q   <= sum_q;
        r_q   <= '0;
        bit_q <= 64'd1 << 62;
        cnt_q <= '0;
      end
      V_SQRT: begin
        if (sq_ge) begin
          x_q <= x_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 5'd1;
      end
      V_DEC: begin
        idx_q    <= 2'd0;
        scaled_q <= cond;
        if (!cond) begin
          for (int i = 0; i < 3; i++) res_q[i] <= orig_q[i];
        end
      end
      V_MUL: begin
        rem_q <= 32'(num[NW-1:QW]);
        nlo_q <= num[QW-1:0];
        q_q   <= '0;
        cnt_q <= '0;
      end
      V_DIV: begin
        rem_q <= rem_nx;
        nlo_q <= nlo_q << 1;
        q_q   <= q_nx;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(QW-1)) begin
          case (idx_q)
            2'd0:    res_q[0] <= neg_q[0] ? -VW'(q_nx) : VW'(q_nx);
            2'd1:    res_q[1] <= neg_q[1] ? -VW'(q_nx) : VW'(q_nx);
            default: res_q[2] <= neg_q[2] ? -VW'(q_nx) : VW'(q_nx);
          endcase
          idx_q <= idx_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o   = state_q != V_IDLE;
  assign done_o   = state_q == V_DONE;
  assign scaled_o = scaled_q;
  assign res_o    = res_q;

endmodule

[design/pss_dp.sv]
module pss_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pss_pkg::cmd_t                 cmd_i,
  output pss_pkg::sts_t                 sts_o,
  input  logic signed [pss_pkg::PW-1:0] tgt_x_i,
  input  logic signed [pss_pkg::PW-1:0] tgt_y_i,
  input  logic signed [pss_pkg::PW-1:0] tgt_z_i,
  input  logic [pss_pkg::DT_W-1:0]      dt_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [pss_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [pss_pkg::UW-1:0] rt_o [3],
  output logic signed [pss_pkg::UW-1:0] up_o [3],
  output logic signed [pss_pkg::UW-1:0] fwd_o [3],
  output logic signed [pss_pkg::PW-1:0] pos_o [3]
);

  localparam int VW = pss_pkg::VW;
  localparam int AW = pss_pkg::AW;
  localparam int UW = pss_pkg::UW;
  localparam int PW = pss_pkg::PW;
  localparam int MW = VW + pss_pkg::DT_W;

  logic signed [PW-1:0]          t_q [3];
  logic [pss_pkg::DT_W-1:0]      dt_q;
  logic [pss_pkg::CFG_W-1:0]     chase_q, smax_q;
  logic signed [PW-1:0]          pos_q [3], vel_q [3];
  logic signed [UW-1:0]          lr_q [3];
  pss_pkg::vw_t                  des_q [3], str_q [3], vt_q [3];
  logic signed [UW-1:0]          fwd_q [3], rt_q [3], up_q [3];
  logic signed [UW-1:0]          o_rt_q [3], o_up_q [3], o_fwd_q [3];
  logic signed [PW-1:0]          o_pos_q [3];
  logic                          out_valid_q;

  pss_pkg::vw_t                  vu_vec [3];
  pss_pkg::vw_t                  vu_res [3];
  logic [pss_pkg::CFG_W-1:0]     vu_tgt;
  logic [pss_pkg::THR_W-1:0]     vu_thr;
  logic                          vu_rnd, vu_clamp, vu_busy, vu_done, vu_scaled;

  logic signed [2*UW-1:0]        fx_sq, fz_sq;
  logic [2*UW:0]                 fsum;
  logic                          near_vert;

  pss_pkg::vw_t                  mdt_src;
  logic                          mdt_neg;
  logic [VW-1:0]                 mdt_mag;
  logic [MW-1:0]                 mdt_prod;
  logic signed [AW-1:0]          mdt_val, vel_sum, pos_sum;

  logic signed [UW-1:0]          ua, ub, uc, ud;
  logic signed [2*UW:0]          udiff;
  logic [2*UW:0]                 umag, urnd;
  logic [UW-1:0]                 uclip;
  logic signed [UW-1:0]          up_val;

  function automatic logic signed [PW-1:0] sat32(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi, lo;
    hi = AW'(32'sh7fffffff);
    lo = -AW'(32'sh7fffffff) - AW'(1);
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[PW-1:0];
  endfunction

  // heading close to vertical: reuse last right vector
  assign fx_sq     = fwd_q[0] * fwd_q[0];
  assign fz_sq     = fwd_q[2] * fwd_q[2];
  assign fsum      = (2*UW+1)'(fx_sq) + (2*UW+1)'(fz_sq);
  assign near_vert = 64'(fsum) < pss_pkg::RIGHT_EPS_SQ;

  always_comb begin
    vu_tgt   = pss_pkg::CFG_W'(pss_pkg::UNIT_ONE);
    vu_rnd   = 1'b0;
    vu_clamp = 1'b0;
    vu_thr   = '0;
    for (int i = 0; i < 3; i++) vu_vec[i] = '0;
    case (cmd_i.src)
      pss_pkg::SRC_D: begin
        for (int i = 0; i < 3; i++) vu_vec[i] = VW'(t_q[i]) - VW'(pos_q[i]);
        vu_tgt = chase_q;
      end
      pss_pkg::SRC_STEER: begin
        for (int i = 0; i < 3; i++) vu_vec[i] = des_q[i] - VW'(vel_q[i]);
        vu_tgt   = smax_q;
        vu_clamp = 1'b1;
      end
      pss_pkg::SRC_VEL: begin
        for (int i = 0; i < 3; i++) vu_vec[i] = vt_q[i];
        vu_tgt   = chase_q;
        vu_clamp = 1'b1;
      end
      pss_pkg::SRC_FWD: begin
        for (int i = 0; i < 3; i++) vu_vec[i] = VW'(vel_q[i]);
        vu_rnd = 1'b1;
        vu_thr = pss_pkg::THR_W'(pss_pkg::SPEED_EPS_SQ - 64'd1);
      end
      pss_pkg::SRC_RT: begin
        if (near_vert) begin
          for (int i = 0; i < 3; i++) vu_vec[i] = VW'(lr_q[i]);
        end else begin
          vu_vec[0] = VW'(fwd_q[2]);
          vu_vec[1] = '0;
          vu_vec[2] = -VW'(fwd_q[0]);
        end
        vu_rnd = 1'b1;
      end
      default: ;
    endcase
  end

  pss_vunit u_vunit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.vu_start),
    .vec_i    (vu_vec),
    .tgt_i    (vu_tgt),
    .rnd_i    (vu_rnd),
    .clamp_i  (vu_clamp),
    .thr_i    (vu_thr),
    .busy_o   (vu_busy),
    .done_o   (vu_done),
    .scaled_o (vu_scaled),
    .res_o    (vu_res)
  );

  // product with the time step, truncated toward zero
  always_comb begin
    case (cmd_i.idx)
      2'd0:    mdt_src = cmd_i.mdt_vel ? str_q[0] : VW'(vel_q[0]);
      2'd1:    mdt_src = cmd_i.mdt_vel ? str_q[1] : VW'(vel_q[1]);
      default: mdt_src = cmd_i.mdt_vel ? str_q[2] : VW'(vel_q[2]);
    endcase
  end

  assign mdt_neg  = mdt_src[VW-1];
  assign mdt_mag  = mdt_neg ? VW'(-mdt_src) : VW'(mdt_src);
  assign mdt_prod = MW'(mdt_mag) * MW'(dt_q);
  assign mdt_val  = mdt_neg ? -AW'(mdt_prod >> pss_pkg::POS_FRAC_BITS)
                            : AW'(mdt_prod >> pss_pkg::POS_FRAC_BITS);

  always_comb begin
    case (cmd_i.idx)
      2'd0: begin
        vel_sum = AW'(vel_q[0]) + mdt_val;
        pos_sum = AW'(pos_q[0]) + mdt_val;
      end
      2'd1: begin
        vel_sum = AW'(vel_q[1]) + mdt_val;
        pos_sum = AW'(pos_q[1]) + mdt_val;
      end
      default: begin
        vel_sum = AW'(vel_q[2]) + mdt_val;
        pos_sum = AW'(pos_q[2]) + mdt_val;
      end
    endcase
  end

  // up = forward cross right, one component a cycle
  always_comb begin
    case (cmd_i.idx)
      2'd0: begin
        ua = fwd_q[1]; ub = rt_q[2]; uc = fwd_q[2]; ud = rt_q[1];
      end
      2'd1: begin
        ua = fwd_q[2]; ub = rt_q[0]; uc = fwd_q[0]; ud = rt_q[2];
      end
      default: begin
        ua = fwd_q[0]; ub = rt_q[1]; uc = fwd_q[1]; ud = rt_q[0];
      end
    endcase
  end

  assign udiff  = (2*UW+1)'(ua) * (2*UW+1)'(ub) - (2*UW+1)'(uc) * (2*UW+1)'(ud);
  assign umag   = udiff[2*UW] ? (2*UW+1)'(-udiff) : (2*UW+1)'(udiff);
  assign urnd   = (umag + (2*UW+1)'(1 << (pss_pkg::UNIT_FRAC_BITS - 1)))
                  >> pss_pkg::UNIT_FRAC_BITS;
  assign uclip  = (urnd > (2*UW+1)'(pss_pkg::UNIT_ONE)) ? pss_pkg::UNIT_ONE : urnd[UW-1:0];
  assign up_val = udiff[2*UW] ? -$signed(uclip) : $signed(uclip);

  // state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chase_q     <= pss_pkg::CHASE_RST;
      smax_q      <= pss_pkg::STEER_RST;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        lr_q[i]  <= '0;
      end
      lr_q[0] <= pss_pkg::UNIT_ONE;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pss_pkg::CFG_CHASE: chase_q <= cfg_data_i;
          pss_pkg::CFG_STEER: smax_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.mdt_pos) begin
        case (cmd_i.idx)
          2'd0:    pos_q[0] <= sat32(pos_sum);
          2'd1:    pos_q[1] <= sat32(pos_sum);
          default: pos_q[2] <= sat32(pos_sum);
        endcase
      end
      if (cmd_i.wb_vel) begin
        for (int i = 0; i < 3; i++) vel_q[i] <= sat32(AW'(vu_res[i]));
      end
      if (cmd_i.wb_right) begin
        if (vu_scaled) begin
          for (int i = 0; i < 3; i++) lr_q[i] <= vu_res[i][UW-1:0];
        end else begin
          lr_q[0] <= pss_pkg::UNIT_ONE;
          lr_q[1] <= '0;
          lr_q[2] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      t_q[0] <= tgt_x_i;
      t_q[1] <= tgt_y_i;
      t_q[2] <= tgt_z_i;
      dt_q   <= dt_i;
    end
    if (cmd_i.wb_des) begin
      for (int i = 0; i < 3; i++) des_q[i] <= vu_scaled ? vu_res[i] : '0;
    end
    if (cmd_i.wb_steer) begin
      for (int i = 0; i < 3; i++) str_q[i] <= vu_res[i];
    end
    if (cmd_i.mdt_vel) begin
      case (cmd_i.idx)
        2'd0:    vt_q[0] <= vel_sum[VW-1:0];
        2'd1:    vt_q[1] <= vel_sum[VW-1:0];
        default: vt_q[2] <= vel_sum[VW-1:0];
      endcase
    end
    if (cmd_i.wb_fwd) begin
      if (vu_scaled) begin
        for (int i = 0; i < 3; i++) fwd_q[i] <= vu_res[i][UW-1:0];
      end else begin
        fwd_q[0] <= '0;
        fwd_q[1] <= '0;
        fwd_q[2] <= pss_pkg::UNIT_ONE;
      end
    end
    if (cmd_i.wb_right) begin
      if (vu_scaled) begin
        for (int i = 0; i < 3; i++) rt_q[i] <= vu_res[i][UW-1:0];
      end else begin
        rt_q[0] <= pss_pkg::UNIT_ONE;
        rt_q[1] <= '0;
        rt_q[2] <= '0;
      end
    end
    if (cmd_i.calc_up) begin
      case (cmd_i.idx)
        2'd0:    up_q[0] <= up_val;
        2'd1:    up_q[1] <= up_val;
        default: up_q[2] <= up_val;
      endcase
    end
    if (cmd_i.load_out) begin
      for (int i = 0; i < 3; i++) begin
        o_rt_q[i]  <= rt_q[i];
        o_up_q[i]  <= up_q[i];
        o_fwd_q[i] <= fwd_q[i];
        o_pos_q[i] <= pos_q[i];
      end
    end
  end

  assign sts_o.vu_busy  = vu_busy;
  assign sts_o.vu_done  = vu_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign rt_o           = o_rt_q;
  assign up_o           = o_up_q;
  assign fwd_o          = o_fwd_q;
  assign pos_o          = o_pos_q;

endmodule

[design/pss_ctrl.sv]
module pss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pss_pkg::sts_t sts_i,
  output pss_pkg::cmd_t cmd_o
);

  localparam logic [3:0] C_IDLE = 4'd0;
  localparam logic [3:0] C_DES  = 4'd1;
  localparam logic [3:0] C_WDES = 4'd2;
  localparam logic [3:0] C_STR  = 4'd3;
  localparam logic [3:0] C_WSTR = 4'd4;
  localparam logic [3:0] C_MDT  = 4'd5;
  localparam logic [3:0] C_VEL  = 4'd6;
  localparam logic [3:0] C_WVEL = 4'd7;
  localparam logic [3:0] C_POS  = 4'd8;
  localparam logic [3:0] C_FWD  = 4'd9;
  localparam logic [3:0] C_WFWD = 4'd10;
  localparam logic [3:0] C_RT   = 4'd11;
  localparam logic [3:0] C_WRT  = 4'd12;
  localparam logic [3:0] C_UP   = 4'd13;
  localparam logic [3:0] C_OUT  = 4'd14;

  logic [3:0] state_q, state_d;
  logic [1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.src = pss_pkg::SRC_D;
    cmd_o.idx = idx_q;
    case (state_q)
      C_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = C_DES;
        end
      end
      C_DES: begin
        cmd_o.vu_start = 1'b1;
        state_d = C_WDES;
      end
      C_WDES: begin
        if (sts_i.vu_done) begin
          cmd_o.wb_des = 1'b1;
          state_d = C_STR;
        end
      end
      C_STR: begin
        cmd_o.vu_start = 1'b1;
        cmd_o.src = pss_pkg::SRC_STEER;
        state_d = C_WSTR;
      end
      C_WSTR: begin
        if (sts_i.vu_done) begin
          cmd_o.wb_steer = 1'b1;
          idx_d = 2'd0;
          state_d = C_MDT;
        end
      end
      C_MDT: begin
        cmd_o.mdt_vel = 1'b1;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd2) state_d = C_VEL;
      end
      C_VEL: begin
        cmd_o.vu_start = 1'b1;
        cmd_o.src = pss_pkg::SRC_VEL;
        state_d = C_WVEL;
      end
      C_WVEL: begin
        if (sts_i.vu_done) begin
          cmd_o.wb_vel = 1'b1;
          idx_d = 2'd0;
          state_d = C_POS;
        end
      end
      C_POS: begin
        cmd_o.mdt_pos = 1'b1;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd2) state_d = C_FWD;
      end
      C_FWD: begin
        cmd_o.vu_start = 1'b1;
        cmd_o.src = pss_pkg::SRC_FWD;
        state_d = C_WFWD;
      end
      C_WFWD: begin
        if (sts_i.vu_done) begin
          cmd_o.wb_fwd = 1'b1;
          state_d = C_RT;
        end
      end
      C_RT: begin
        cmd_o.vu_start = 1'b1;
        cmd_o.src = pss_pkg::SRC_RT;
        state_d = C_WRT;
      end
      C_WRT: begin
        if (sts_i.vu_done) begin
          cmd_o.wb_right = 1'b1;
          idx_d = 2'd0;
          state_d = C_UP;
        end
      end
      C_UP: begin
        cmd_o.calc_up = 1'b1;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd2) state_d = C_OUT;
      end
      C_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign in_ready_o = state_q == C_IDLE;

endmodule

[design/pursuit_steering_step.sv]
// pursuit steering step: one input item is one time step of a pursuer
// chasing a target point (target_x/y/z in Q16.16, step_time in Q4.16).
// each item gives exactly one result item: the heading frame right, up,
// forward (Q1.14) and the new pursuer position (Q16.16, saturating).
// channels are valid/ready; an item moves when both are high.
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 chase_speed, 1 max_steer); write only while the block is idle.
// one item at a time: in.ready is high only while no step is running.
// five vector stages (desired, steer clamp, speed clamp, forward, right)
// share one vector unit: a bit-serial square root, then the restoring
// divider, one component after another, when the vector is rescaled.
// the result sits in an output register; a stalled receiver holds it and
// the next item is still taken, stalling only at the end of its step.
// reset puts the pursuer at the origin at rest with right = +x and loads
// the register defaults; no clearing pass is needed.
module pursuit_steering_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pss_in_if.sink                     in_i,
  pss_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [pss_pkg::CFG_W-1:0]  cfg_data_i
);

  pss_pkg::cmd_t cmd;
  pss_pkg::sts_t sts;

  logic signed [pss_pkg::UW-1:0] rt [3];
  logic signed [pss_pkg::UW-1:0] up [3];
  logic signed [pss_pkg::UW-1:0] fwd [3];
  logic signed [pss_pkg::PW-1:0] pos [3];

  pss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .tgt_x_i     (in_i.target_x),
    .tgt_y_i     (in_i.target_y),
    .tgt_z_i     (in_i.target_z),
    .dt_i        (in_i.step_time),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .rt_o        (rt),
    .up_o        (up),
    .fwd_o       (fwd),
    .pos_o       (pos)
  );

  assign out_o.right_x = rt[0];
  assign out_o.right_y = rt[1];
  assign out_o.right_z = rt[2];
  assign out_o.up_x    = up[0];
  assign out_o.up_y    = up[1];
  assign out_o.up_z    = up[2];
  assign out_o.fwd_x   = fwd[0];
  assign out_o.fwd_y   = fwd[1];
  assign out_o.fwd_z   = fwd[2];
  assign out_o.pos_x   = pos[0];
  assign out_o.pos_y   = pos[1];
  assign out_o.pos_z   = pos[2];

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second item taken while a step runs");

  a_vu_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.vu_start |-> !sts.vu_busy)
    else $error("vector unit started while busy");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_o.valid)
    else $error("result load did not raise valid");

endmodule
